### rtl/priority_run_queue_defines.svh
// Assertion macros used by the run queue RTL.
`ifndef PRIORITY_RUN_QUEUE_DEFINES_SVH
`define PRIORITY_RUN_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PRQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/prq_pkg.sv
// Opcode type shared by the run queue and its users.
`default_nettype none

package prq_pkg;

  typedef enum logic [1:0] {
    OP_READY = 2'd0,
    OP_PICK  = 2'd1,
    OP_STOP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

endpackage

`default_nettype wire

### rtl/priority_run_queue.sv
// Multilevel priority FIFO run queue with a linked-list walker.
//
// Usage: drive opcode and its fields with start high; the transaction is
// taken at a rising edge where start is high and busy is low. Exactly one
// result per transaction appears on the result ports with done high for
// one cycle; the receiver cannot stall it and must take it then.
// Sequence: set stop or an unused opcode goes straight to the report
//   state; make ready checks the queued mark and links the slot behind
//   the level's tail when the level already holds slots; pick visits
//   levels in order and examines each list slot with one read of the
//   link/stop memories until a runnable slot is granted or none is.
// The list walk through the link memory sets the pick time; a new
// transaction can be taken in the cycle done is high.
// Reset: a clearing pass over all SLOTS slots zeroes the stop flags and
// queued marks; busy stays high during it. Level heads and tails reset to
// empty, the ready count to zero and the best-level hint to LEVELS.
`default_nettype none
`include "priority_run_queue_defines.svh"

module priority_run_queue #(
  parameter int LEVELS = 8,
  parameter int SLOTS  = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  prq_pkg::op_t                opcode,
  input  logic [$clog2(SLOTS)-1:0]    proc_slot,
  input  logic [$clog2(LEVELS)-1:0]   priority_req,
  input  logic                        stop_value,
  input  logic [$clog2(LEVELS)-1:0]   current_priority,
  input  logic                        current_valid,
  output logic                        done,
  output logic                        granted,
  output logic [$clog2(SLOTS)-1:0]    granted_slot,
  output logic [$clog2(LEVELS)-1:0]   granted_level,
  output logic [$clog2(SLOTS+1)-1:0]  ready_count,
  output logic                        any_ready,
  output logic                        any_higher
);
  import prq_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW = $clog2(SLOTS + 1);
  localparam int VW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int HW = $clog2(LEVELS + 1);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NIL      = LW'(SLOTS);
  localparam logic [HW-1:0] LEV_NONE = HW'(LEVELS);
  localparam logic [IW-1:0] CLR_LAST = IW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MR_CHK,
    S_MR_LINK,
    S_PK_LVL,
    S_PK_CHK,
    S_REPORT
  } state_t;

  state_t        state;
  logic [LW-1:0] level_head [LEVELS];
  logic [LW-1:0] level_tail [LEVELS];
  logic [CW-1:0] count;
  logic [HW-1:0] hint;
  logic [HW-1:0] lvl;
  logic [IW-1:0] slot;
  logic [LW-1:0] cur;
  logic [LW-1:0] prev;
  logic          grant;
  logic [VW-1:0] run_pri;
  logic          run_valid;
  logic [IW-1:0] clr;

  // Per-slot memories
  logic [LW-1:0] link_mem [SLOTS];
  logic          stop_mem [SLOTS];
  logic          inq_mem  [SLOTS];
  logic [LW-1:0] link_rd;
  logic          stop_rd;
  logic          inq_rd;

  logic [IW-1:0] rd_addr;
  logic          link_we;
  logic [IW-1:0] link_wa;
  logic [LW-1:0] link_wd;
  logic          stop_we;
  logic [IW-1:0] stop_wa;
  logic          stop_wd;
  logic          inq_we;
  logic [IW-1:0] inq_wa;
  logic          inq_wd;

  logic          accept;
  logic          slot_ok;
  logic          lvl_ok;
  logic [VW-1:0] lvl_idx;
  logic [LW-1:0] slot_link;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign slot_ok   = (32'(proc_slot) < SLOTS);
  assign lvl_ok    = (32'(priority_req) < LEVELS);
  assign lvl_idx   = lvl[VW-1:0];
  assign slot_link = LW'(slot);

  // Select memory read address and write ports per state
  always_comb begin
    rd_addr = IW'(proc_slot);
    link_we = 1'b0;
    link_wa = slot;
    link_wd = NIL;
    stop_we = 1'b0;
    stop_wa = clr;
    stop_wd = 1'b0;
    inq_we  = 1'b0;
    inq_wa  = clr;
    inq_wd  = 1'b0;
    case (state)
      S_CLEAR: begin
        stop_we = 1'b1;
        inq_we  = 1'b1;
      end
      S_IDLE: begin
        if (accept && opcode == OP_STOP && slot_ok) begin
          stop_we = 1'b1;
          stop_wa = IW'(proc_slot);
          stop_wd = stop_value;
        end
      end
      S_MR_CHK: begin
        if (!inq_rd) begin
          link_we = 1'b1;
          inq_we  = 1'b1;
          inq_wa  = slot;
          inq_wd  = 1'b1;
        end
      end
      S_MR_LINK: begin
        link_we = 1'b1;
        link_wa = prev[IW-1:0];
        link_wd = slot_link;
      end
      S_PK_LVL: begin
        rd_addr = level_head[lvl_idx][IW-1:0];
      end
      S_PK_CHK: begin
        rd_addr = link_rd[IW-1:0];
        if (!stop_rd) begin
          inq_we  = 1'b1;
          inq_wa  = cur[IW-1:0];
          link_we = (prev != NIL);
          link_wa = prev[IW-1:0];
          link_wd = link_rd;
        end
      end
      default: begin
      end
    endcase
  end

  // Link memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd <= link_mem[rd_addr];
  end

  // Stop flag memory
  always_ff @(posedge clk) begin
    if (stop_we) stop_mem[stop_wa] <= stop_wd;
    stop_rd <= stop_mem[rd_addr];
  end

  // Queued mark memory
  always_ff @(posedge clk) begin
    if (inq_we) inq_mem[inq_wa] <= inq_wd;
    inq_rd <= inq_mem[rd_addr];
  end

  // Sequencer, list registers and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      count <= '0;
      hint  <= LEV_NONE;
      done  <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        level_head[i] <= NIL;
        level_tail[i] <= NIL;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == CLR_LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            grant     <= 1'b0;
            run_pri   <= current_priority;
            run_valid <= current_valid;
            slot      <= IW'(proc_slot);
            lvl       <= (opcode == OP_PICK) ? '0 : HW'(priority_req);
            case (opcode)
              OP_READY: state <= (slot_ok && lvl_ok) ? S_MR_CHK : S_REPORT;
              OP_PICK:  state <= S_PK_LVL;
              default:  state <= S_REPORT;
            endcase
          end
        end
        S_MR_CHK: begin
          // Drop a slot that is already queued
          if (inq_rd) begin
            state <= S_REPORT;
          end else begin
            count <= count + 1'b1;
            if (lvl < hint) hint <= lvl;
            level_tail[lvl_idx] <= slot_link;
            if (level_tail[lvl_idx] != NIL) begin
              prev  <= level_tail[lvl_idx];
              state <= S_MR_LINK;
            end else begin
              level_head[lvl_idx] <= slot_link;
              state               <= S_REPORT;
            end
          end
        end
        S_MR_LINK: begin
          state <= S_REPORT;
        end
        S_PK_LVL: begin
          // Advance past empty levels; give up after the last one
          if (lvl == LEV_NONE) begin
            hint  <= LEV_NONE;
            state <= S_REPORT;
          end else if (level_head[lvl_idx] == NIL) begin
            lvl <= lvl + 1'b1;
          end else begin
            cur   <= level_head[lvl_idx];
            prev  <= NIL;
            state <= S_PK_CHK;
          end
        end
        S_PK_CHK: begin
          if (!stop_rd) begin
            // Unlink the first runnable slot
            grant <= 1'b1;
            count <= count - 1'b1;
            if (prev == NIL) level_head[lvl_idx] <= link_rd;
            if (link_rd == NIL) begin
              level_tail[lvl_idx] <= prev;
              hint                <= HW'(lvl + 1'b1);
            end else begin
              hint <= lvl;
            end
            state <= S_REPORT;
          end else begin
            // Walk past a stopped slot
            prev <= cur;
            cur  <= link_rd;
            if (link_rd == NIL) begin
              lvl   <= lvl + 1'b1;
              state <= S_PK_LVL;
            end
          end
        end
        S_REPORT: begin
          done          <= 1'b1;
          granted       <= grant;
          granted_slot  <= grant ? cur[IW-1:0] : '0;
          granted_level <= grant ? lvl[VW-1:0] : '0;
          ready_count   <= count;
          any_ready     <= (count != '0);
          any_higher    <= run_valid && (count != '0) && (32'(hint) < 32'(run_pri));
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PRQ_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `PRQ_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "accepted transaction not in work")
  `PRQ_ASSERT_IMP(a_nogrant_zero, clk, rst, done && !granted,
                  granted_slot == '0 && granted_level == '0,
                  "ungranted result carries a slot")
  `PRQ_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(SLOTS), "ready count exceeds slot count")

endmodule

`default_nettype wire
